[rtl/lkvc_pkg.sv]
// Shared constants for the LRU key/value cache.
`default_nettype none

package lkvc_pkg;

    // Key and value width
    localparam int DATA_W = 32;

    // Capacity register
    localparam int CAP_W = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Operation codes
    localparam logic OP_GET = 1'b0;
    localparam logic OP_SET = 1'b1;

endpackage

`default_nettype wire

[rtl/lkvc_lookup.sv]
// Parallel key compare across all entries, with hit data and hit age select.
`default_nettype none

module lkvc_lookup #(
    parameter int N     = 16,
    parameter int AGE_W = 4
) (
    input  wire logic [lkvc_pkg::DATA_W-1:0] key,
    input  wire logic [N-1:0]                valid,
    input  wire logic [lkvc_pkg::DATA_W-1:0] entry_key  [N],
    input  wire logic [lkvc_pkg::DATA_W-1:0] entry_data [N],
    input  wire logic [AGE_W-1:0]            entry_age  [N],
    output logic                             hit,
    output logic [N-1:0]                     hit_oh,
    output logic [lkvc_pkg::DATA_W-1:0]      hit_data,
    output logic [AGE_W-1:0]                 hit_age
);

    logic [N-1:0] match;

    // One comparator per entry
    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            match[i] = valid[i] && (entry_key[i] == key);
        end
    end

    // Keep the lowest match only; valid keys are distinct anyway
    assign hit_oh = match & (~match + N'(1));
    assign hit    = |match;

    // AND-OR select of the hit entry's data and age
    always_comb
    begin
        hit_data = '0;
        hit_age  = '0;
        for (int i = 0; i < N; i++)
        begin
            hit_data = hit_data | (entry_data[i] & {lkvc_pkg::DATA_W{hit_oh[i]}});
            hit_age  = hit_age | (entry_age[i] & {AGE_W{hit_oh[i]}});
        end
    end

endmodule

`default_nettype wire

[rtl/lkvc_victim.sv]
// Slot choice for a set miss: the oldest entry when full, else the first free one.
`default_nettype none

module lkvc_victim #(
    parameter int N     = 16,
    parameter int AGE_W = 4,
    parameter int CNT_W = 5
) (
    input  wire logic [N-1:0]                valid,
    input  wire logic [AGE_W-1:0]            entry_age [N],
    input  wire logic [lkvc_pkg::DATA_W-1:0] entry_key [N],
    input  wire logic [CNT_W-1:0]            fill,
    input  wire logic [lkvc_pkg::CAP_W-1:0]  capacity,
    output logic                             full,
    output logic [N-1:0]                     slot_oh,
    output logic [lkvc_pkg::DATA_W-1:0]      victim_key
);

    localparam int CMP_W = (CNT_W > lkvc_pkg::CAP_W) ? CNT_W : lkvc_pkg::CAP_W;

    logic [CMP_W-1:0] cap_ext;
    logic [CMP_W-1:0] max_ext;
    logic [CMP_W-1:0] eff_cap;
    logic [CNT_W-1:0] oldest;
    logic [N-1:0]     old_oh;
    logic [N-1:0]     free;
    logic [N-1:0]     free_oh;

    // Effective capacity: zero acts as one, clamp at the entry count
    assign cap_ext = CMP_W'(capacity);
    assign max_ext = CMP_W'(N);

    always_comb
    begin
        if (capacity == '0)
        begin
            eff_cap = CMP_W'(1);
        end
        else if (cap_ext > max_ext)
        begin
            eff_cap = max_ext;
        end
        else
        begin
            eff_cap = cap_ext;
        end
    end

    assign full = (CMP_W'(fill) >= eff_cap);

    // Valid ages are a permutation of 0..fill-1, so the oldest has age fill-1
    assign oldest = fill - CNT_W'(1);

    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            old_oh[i] = valid[i] && (CNT_W'(entry_age[i]) == oldest);
        end
    end

    // First free entry
    assign free    = ~valid;
    assign free_oh = free & (~free + N'(1));

    assign slot_oh = full ? old_oh : free_oh;

    // Key of the entry about to be evicted
    always_comb
    begin
        victim_key = '0;
        for (int i = 0; i < N; i++)
        begin
            victim_key = victim_key
                       | (entry_key[i] & {lkvc_pkg::DATA_W{old_oh[i] & full}});
        end
    end

endmodule

`default_nettype wire

[rtl/lru_key_value_cache.sv]
// Top level of the fully associative LRU key/value cache.
//
// Usage:
//   Command channel: an access is taken at a clock edge with start high and
//   busy low. busy is always low, so one access can be issued every cycle.
//   operation selects get or set; key and write_value travel with it.
//   Result channel: done is high for exactly one cycle with found,
//   read_value, evicted and evicted_key. The receiver cannot stall; a
//   result is gone after its cycle.
//   An accepted access passes through the input register, then one pass
//   of key compare and age update into the result register, which drives
//   the result beat on the ports. Throughput: one access per cycle, set by
//   the key compare across all entries and the age update of every entry.
//   Configuration: cfg_wr_en writes cfg_wr_data into the capacity register;
//   write it only while no access is in flight.
//   Reset: all entries invalid, ages and fill count cleared, capacity 16.
//   No clearing pass is needed; the block takes accesses right away.
`default_nettype none

module lru_key_value_cache #(
    parameter int MAX_ENTRIES = 16
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic                               operation,
    input  wire logic signed [lkvc_pkg::DATA_W-1:0] key,
    input  wire logic signed [lkvc_pkg::DATA_W-1:0] write_value,
    input  wire logic                               cfg_wr_en,
    input  wire logic [lkvc_pkg::CAP_W-1:0]         cfg_wr_data,
    output logic                                    done,
    output logic                                    found,
    output logic signed [lkvc_pkg::DATA_W-1:0]      read_value,
    output logic                                    evicted,
    output logic signed [lkvc_pkg::DATA_W-1:0]      evicted_key
);

    localparam int AGE_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int DW    = lkvc_pkg::DATA_W;

    // Input register
    logic          in_valid_reg;
    logic          op_reg;
    logic [DW-1:0] key_reg;
    logic [DW-1:0] wval_reg;

    // Entry store
    logic [MAX_ENTRIES-1:0]     valid_reg;
    logic [MAX_ENTRIES-1:0]     valid_next;
    logic [AGE_W-1:0]           age_reg   [MAX_ENTRIES];
    logic [AGE_W-1:0]           age_next  [MAX_ENTRIES];
    logic [DW-1:0]              ekey_reg  [MAX_ENTRIES];
    logic [DW-1:0]              ekey_next [MAX_ENTRIES];
    logic [DW-1:0]              edata_reg [MAX_ENTRIES];
    logic [DW-1:0]              edata_next[MAX_ENTRIES];
    logic [CNT_W-1:0]           fill_reg;
    logic [CNT_W-1:0]           fill_next;
    logic [lkvc_pkg::CAP_W-1:0] cap_reg;

    // Result register
    logic          done_reg;
    logic          found_reg;
    logic          found_next;
    logic [DW-1:0] read_reg;
    logic [DW-1:0] read_next;
    logic          evicted_reg;
    logic          evicted_next;
    logic [DW-1:0] evkey_reg;
    logic [DW-1:0] evkey_next;

    // Lookup and slot choice
    logic                   hit;
    logic [MAX_ENTRIES-1:0] hit_oh;
    logic [DW-1:0]          hit_data;
    logic [AGE_W-1:0]       hit_age;
    logic                   full;
    logic [MAX_ENTRIES-1:0] slot_oh;
    logic [DW-1:0]          victim_key;

    assign busy = 1'b0;

    // Capture the command beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            op_reg   <= operation;
            key_reg  <= key;
            wval_reg <= write_value;
        end
    end

    // Capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= lkvc_pkg::CAP_RESET;
        end
        else if (cfg_wr_en)
        begin
            cap_reg <= cfg_wr_data;
        end
    end

    lkvc_lookup #(
        .N     (MAX_ENTRIES),
        .AGE_W (AGE_W)
    ) u_lookup (
        .key        (key_reg),
        .valid      (valid_reg),
        .entry_key  (ekey_reg),
        .entry_data (edata_reg),
        .entry_age  (age_reg),
        .hit        (hit),
        .hit_oh     (hit_oh),
        .hit_data   (hit_data),
        .hit_age    (hit_age)
    );

    lkvc_victim #(
        .N     (MAX_ENTRIES),
        .AGE_W (AGE_W),
        .CNT_W (CNT_W)
    ) u_victim (
        .valid      (valid_reg),
        .entry_age  (age_reg),
        .entry_key  (ekey_reg),
        .fill       (fill_reg),
        .capacity   (cap_reg),
        .full       (full),
        .slot_oh    (slot_oh),
        .victim_key (victim_key)
    );

    // Next state of the entries and the result beat
    always_comb
    begin
        valid_next   = valid_reg;
        fill_next    = fill_reg;
        found_next   = 1'b0;
        read_next    = '0;
        evicted_next = 1'b0;
        evkey_next   = '0;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            age_next[i]   = age_reg[i];
            ekey_next[i]  = ekey_reg[i];
            edata_next[i] = edata_reg[i];
        end

        if (in_valid_reg)
        begin
            if (hit)
            begin
                // Hit: update or read, then make the entry most recent
                found_next = 1'b1;
                if (op_reg == lkvc_pkg::OP_GET)
                begin
                    read_next = hit_data;
                end
                for (int i = 0; i < MAX_ENTRIES; i++)
                begin
                    if (valid_reg[i] && (age_reg[i] < hit_age))
                    begin
                        age_next[i] = age_reg[i] + AGE_W'(1);
                    end
                    if (hit_oh[i])
                    begin
                        age_next[i] = '0;
                        if (op_reg == lkvc_pkg::OP_SET)
                        begin
                            edata_next[i] = wval_reg;
                        end
                    end
                end
            end
            else if (op_reg == lkvc_pkg::OP_SET)
            begin
                // Set miss: age everyone, drop the oldest if full, insert
                evicted_next = full;
                evkey_next   = victim_key;
                if (!full)
                begin
                    fill_next = fill_reg + CNT_W'(1);
                end
                for (int i = 0; i < MAX_ENTRIES; i++)
                begin
                    if (valid_reg[i])
                    begin
                        age_next[i] = age_reg[i] + AGE_W'(1);
                    end
                    if (slot_oh[i])
                    begin
                        valid_next[i] = 1'b1;
                        age_next[i]   = '0;
                        ekey_next[i]  = key_reg;
                        edata_next[i] = wval_reg;
                    end
                end
            end
        end
    end

    // Control state of the entries
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            fill_reg  <= '0;
            done_reg  <= 1'b0;
            for (int i = 0; i < MAX_ENTRIES; i++)
            begin
                age_reg[i] <= '0;
            end
        end
        else
        begin
            valid_reg <= valid_next;
            fill_reg  <= fill_next;
            done_reg  <= in_valid_reg;
            for (int i = 0; i < MAX_ENTRIES; i++)
            begin
                age_reg[i] <= age_next[i];
            end
        end
    end

    // Entry payload and result payload
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            ekey_reg[i]  <= ekey_next[i];
            edata_reg[i] <= edata_next[i];
        end
        found_reg   <= found_next;
        read_reg    <= read_next;
        evicted_reg <= evicted_next;
        evkey_reg   <= evkey_next;
    end

    assign done        = done_reg;
    assign found       = found_reg;
    assign read_value  = read_reg;
    assign evicted     = evicted_reg;
    assign evicted_key = evkey_reg;

`ifndef NO_ASSERTIONS
    // Every accepted command yields its result beat through the input and result registers
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("accepted command produced no result beat");

    // No result beat without an accepted command ahead of it through both registers
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 2))
        else $error("result beat without a command");

    // Fill count tracks the number of valid entries
    a_fill_count: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg == CNT_W'($countones(valid_reg)))
        else $error("fill count disagrees with valid bits");

    // At most one entry is selected as the hit
    a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg |-> $onehot0(hit_oh))
        else $error("more than one entry hit");

    // An eviction only happens on a miss
    a_evict_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (done && evicted) |-> !found)
        else $error("eviction reported on a hit");
`endif

endmodule

`default_nettype wire
